// ----- design/ppr_pkg.sv -----
// Package: payload types, constants and the sequencer microprogram for parent path rebuild.
package ppr_pkg;

  localparam int NODES       = 63;
  localparam int NODE_W      = 6;
  localparam int CNT_W       = 7;
  localparam int TABLE_DEPTH = 1 << NODE_W;
  localparam int STACK_DEPTH = NODES;
  localparam int STEP_W      = 3;

  typedef struct packed {
    logic              func;
    logic [NODE_W-1:0] node_index;
    logic [NODE_W-1:0] parent_value;
    logic [NODE_W-1:0] start_node;
    logic [NODE_W-1:0] end_node;
  } ppr_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] path_node;
    logic              found;
    logic              last;
  } ppr_out_t;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE  = 3'd0;
  localparam step_t ST_CHK   = 3'd1;
  localparam step_t ST_LINK  = 3'd2;
  localparam step_t ST_PUSH  = 3'd3;
  localparam step_t ST_START = 3'd4;
  localparam step_t ST_POP   = 3'd5;
  localparam step_t ST_EMIT  = 3'd6;
  localparam step_t ST_NF    = 3'd7;

  typedef enum logic [2:0] {
    C_QUERY,
    C_BAD,
    C_END,
    C_FULL,
    C_MISS,
    C_EMPTY,
    C_BUSY
  } cond_t;

  typedef struct packed {
    logic  take_in;
    logic  rd_ptab;
    logic  push_node;
    logic  push_start;
    logic  pop;
    logic  emit_path;
    logic  emit_nf;
    logic  act_on_false;
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t pc);
    ucode_t w;
    w = '0;
    unique case (pc)
      ST_IDLE: begin
        w.take_in = 1'b1;
        w.cond    = C_QUERY;
        w.tgt_t   = ST_CHK;
        w.tgt_f   = ST_IDLE;
      end
      ST_CHK: begin
        w.rd_ptab = 1'b1;
        w.cond    = C_BAD;
        w.tgt_t   = ST_NF;
        w.tgt_f   = ST_LINK;
      end
      ST_LINK: begin
        w.cond  = C_END;
        w.tgt_t = ST_START;
        w.tgt_f = ST_PUSH;
      end
      ST_PUSH: begin
        w.push_node    = 1'b1;
        w.act_on_false = 1'b1;
        w.cond         = C_FULL;
        w.tgt_t        = ST_NF;
        w.tgt_f        = ST_CHK;
      end
      ST_START: begin
        w.push_start   = 1'b1;
        w.act_on_false = 1'b1;
        w.cond         = C_MISS;
        w.tgt_t        = ST_NF;
        w.tgt_f        = ST_POP;
      end
      ST_POP: begin
        w.pop          = 1'b1;
        w.act_on_false = 1'b1;
        w.cond         = C_EMPTY;
        w.tgt_t        = ST_IDLE;
        w.tgt_f        = ST_EMIT;
      end
      ST_EMIT: begin
        w.emit_path    = 1'b1;
        w.act_on_false = 1'b1;
        w.cond         = C_BUSY;
        w.tgt_t        = ST_EMIT;
        w.tgt_f        = ST_POP;
      end
      ST_NF: begin
        w.emit_nf      = 1'b1;
        w.act_on_false = 1'b1;
        w.cond         = C_BUSY;
        w.tgt_t        = ST_NF;
        w.tgt_f        = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- design/ppr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ppr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/parent_path_rebuild_top.sv -----
// Top level: microcoded path rebuild from a parent table.
// Holds a parent table for nodes 1..63. A write transaction (func 0) stores one
// parent entry. A query transaction (func 1) walks parent links from end_node
// until a node without a parent, then, if that node is start_node, returns the path
// from start to end, one node per output transaction, with last on the final one;
// otherwise a single transaction with found = 0 and last = 1. A walk that reaches a
// 63rd node that still has a parent counts as not found. Querying through a parent
// entry that was never written gives undefined results. Timing is set by an
// eight-step microprogram and the single read port of each table; a query lasts
// longer the more links it walks, plus any output stall. New input is taken only
// between queries; the output register lets a result wait while the next
// transaction is accepted.
module parent_path_rebuild_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ppr_pkg::ppr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ppr_pkg::ppr_out_t out_data
);

  import ppr_pkg::*;

  localparam int SAW = $clog2(STACK_DEPTH);

  step_t    pc_r, pc_nxt;
  ucode_t   uw;
  logic     cond_hit;
  logic     act;
  logic     in_acc;
  logic     out_busy;
  logic     emit;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_m1;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [NODE_W-1:0] start_r, start_nxt;
  logic              out_valid_r, out_valid_nxt;
  ppr_out_t          out_data_r, out_data_nxt;

  logic              ptab_we;
  logic [NODE_W-1:0] ptab_rd;
  logic              stk_we;
  logic              stk_re;
  logic [NODE_W-1:0] stk_wdata;
  logic [NODE_W-1:0] stk_rd;

  assign uw       = ucode_rom(pc_r);
  assign in_ready = uw.take_in;
  assign in_acc   = in_valid && in_ready;
  assign out_busy = out_valid_r && !out_ready;
  assign cnt_m1   = cnt_r - CNT_W'(1);

  always_comb begin
    unique case (uw.cond)
      C_QUERY: cond_hit = in_valid && (in_data.func == FUNC_QUERY);
      C_BAD:   cond_hit = (node_r == '0) || ({1'b0, node_r} > CNT_W'(NODES));
      C_END:   cond_hit = (ptab_rd == '0);
      C_FULL:  cond_hit = (cnt_r >= CNT_W'(NODES - 1));
      C_MISS:  cond_hit = (node_r != start_r);
      C_EMPTY: cond_hit = (cnt_r == '0);
      C_BUSY:  cond_hit = out_busy;
      default: cond_hit = 1'b0;
    endcase
  end

  assign act    = uw.act_on_false ? !cond_hit : 1'b1;
  assign pc_nxt = cond_hit ? uw.tgt_t : uw.tgt_f;
  assign emit   = act && (uw.emit_path || uw.emit_nf);

  assign ptab_we = in_acc && (in_data.func == FUNC_WRITE) && (in_data.node_index != '0) &&
                   ({1'b0, in_data.node_index} <= CNT_W'(NODES));

  assign stk_we    = act && (uw.push_node || uw.push_start);
  assign stk_re    = act && uw.pop;
  assign stk_wdata = uw.push_node ? node_r : start_r;

  ppr_ram #(
    .WIDTH (NODE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ptab (
    .clk   (clk),
    .we    (ptab_we),
    .waddr (in_data.node_index),
    .wdata (in_data.parent_value),
    .re    (uw.rd_ptab),
    .raddr (node_r),
    .rdata (ptab_rd)
  );

  ppr_ram #(
    .WIDTH (NODE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (cnt_r[SAW-1:0]),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (cnt_m1[SAW-1:0]),
    .rdata (stk_rd)
  );

  always_comb begin
    node_nxt      = node_r;
    start_nxt     = start_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_acc) begin
      node_nxt  = in_data.end_node;
      start_nxt = in_data.start_node;
      cnt_nxt   = '0;
    end
    if (act && uw.push_node) begin
      node_nxt = ptab_rd;
    end
    if (stk_we) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (stk_re) begin
      cnt_nxt = cnt_m1;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (uw.emit_path) begin
        out_data_nxt.path_node = stk_rd;
        out_data_nxt.found     = 1'b1;
        out_data_nxt.last      = (cnt_r == '0);
      end else begin
        out_data_nxt.path_node = '0;
        out_data_nxt.found     = 1'b0;
        out_data_nxt.last      = 1'b1;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    start_r    <= start_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !out_busy)
    else $error("result loaded while output register still occupied");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NODES))
    else $error("path stack depth out of range");

  a_nf_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.found) |-> (out_data_r.last && out_data_r.path_node == '0))
    else $error("not-found result malformed");

  a_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == ST_EMIT && !out_busy && cnt_r == '0) |=> (pc_r == ST_POP && cnt_r == '0))
    else $error("sequencer left path emission without draining stack");
`endif

endmodule

// ----- verif/parent_path_rebuild_top_tb.sv -----
// Testbench for parent_path_rebuild_top: table writes and path queries checked against a predictor.
`timescale 1ns / 100ps

module parent_path_rebuild_top_tb;
  import ppr_pkg::*;

  localparam int MAX_WAIT    = 13;
  localparam int RAND_ITEMS  = 150;
  localparam int DRAIN_CYC   = 400;
  localparam int CLK_HALF    = 10;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  ppr_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ppr_out_t out_data;

  parent_path_rebuild_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // stimulus plan, filled up front
  ppr_in_t    pending_items[$];
  bit         pending_hold[$];
  int         plan_parent[64];
  bit         plan_written[64];
  int         live_items;

  // predictor state and expected results
  logic [NODE_W-1:0] model_parent[64];
  ppr_out_t          expected_hops[$];

  bit  in_took, out_took;
  bit  send_calm, recv_calm;
  int  send_gap, recv_stall;
  int  fail_cnt, cycle_cnt, cycle_limit;
  int  txn_cnt, query_cnt, hop_cnt, path_cnt, miss_cnt, longest_path, cur_len;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic put_write(input int idx, input int par);
    ppr_in_t it;
    it.func         = FUNC_WRITE;
    it.node_index   = idx[NODE_W-1:0];
    it.parent_value = par[NODE_W-1:0];
    it.start_node   = NODE_W'($urandom_range(0, 63));
    it.end_node     = NODE_W'($urandom_range(0, 63));
    pending_items   = {pending_items, it};
    pending_hold    = {pending_hold, 1'b0};
    if (idx >= 1 && idx <= NODES) begin
      plan_parent[idx]  = par;
      plan_written[idx] = 1'b1;
      live_items++;
    end
  endtask

  // every entry the walk will read gets written first
  task automatic put_query(input int src, input int dst);
    ppr_in_t it;
    int      node, step;
    node = dst;
    for (step = 0; step < 64 && node != 0; step++) begin
      if (!plan_written[node])
        put_write(node, ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, NODES));
      node = plan_parent[node];
    end
    it.func         = FUNC_QUERY;
    it.node_index   = NODE_W'($urandom_range(0, 63));
    it.parent_value = NODE_W'($urandom_range(0, 63));
    it.start_node   = src[NODE_W-1:0];
    it.end_node     = dst[NODE_W-1:0];
    pending_items   = {pending_items, it};
    pending_hold    = {pending_hold, 1'b0};
    live_items++;
  endtask

  task automatic hold_last();
    pending_hold[pending_hold.size()-1] = 1'b1;
  endtask

  // root plus len linked nodes, then queries over it
  task automatic run_chain(input int len, input bit plain);
    int pool[$];
    int links[$];
    int root, pick, k;
    root = $urandom_range(1, NODES);
    for (k = 1; k <= NODES; k++)
      if (k != root) pool = {pool, k};
    links = {links, root};
    for (k = 0; k < len; k++) begin
      pick = $urandom_range(0, pool.size() - 1);
      links = {links, pool[pick]};
      pool.delete(pick);
    end
    put_write(root, 0);
    if ($urandom_range(0, 2) == 0) begin
      for (k = len; k >= 1; k--) put_write(links[k], links[k-1]);
    end else begin
      for (k = 1; k <= len; k++) put_write(links[k], links[k-1]);
    end
    if (plain) begin
      put_query(root, links[len]);
    end else begin
      case ($urandom_range(0, 5))
        0: put_query($urandom_range(1, NODES), links[len]);
        1: begin
          put_write(root, links[len]);
          put_query(root, links[len]);
        end
        default: put_query(root, links[len]);
      endcase
      if ($urandom_range(0, 2) == 0) put_query(root, links[$urandom_range(0, len)]);
    end
  endtask

  task automatic trace_path(input ppr_in_t it);
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] trail[$];
    ppr_out_t          r;
    int                hops, k;
    bit                miss;
    if (it.func == FUNC_WRITE) begin
      if (it.node_index >= 1 && it.node_index <= NODES)
        model_parent[it.node_index] = it.parent_value;
      return;
    end
    query_cnt++;
    node = it.end_node;
    miss = (node < 1 || node > NODES);
    hops = 0;
    while (!miss && model_parent[node] != '0) begin
      if (hops >= NODES - 1) begin
        miss = 1'b1;
      end else begin
        trail = {trail, node};
        hops++;
        node = model_parent[node];
        if (node > NODES) miss = 1'b1;
      end
    end
    if (!miss && node != it.start_node) miss = 1'b1;
    if (miss) begin
      r.path_node   = '0;
      r.found       = 1'b0;
      r.last        = 1'b1;
      expected_hops = {expected_hops, r};
      miss_cnt++;
    end else begin
      trail = {trail, node};
      for (k = trail.size() - 1; k >= 0; k--) begin
        r.path_node   = trail[k];
        r.found       = 1'b1;
        r.last        = (k == 0);
        expected_hops = {expected_hops, r};
      end
    end
  endtask

  task automatic check_hop(input ppr_out_t got);
    ppr_out_t want;
    if (expected_hops.size() == 0) begin
      $error("result with nothing pending: path_node %0d found %0b last %0b",
             got.path_node, got.found, got.last);
      fail_cnt++;
    end else begin
      want = expected_hops.pop_front();
      if (got.path_node !== want.path_node) begin
        $error("path_node: expected %0d, actual %0d", want.path_node, got.path_node);
        fail_cnt++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0b, actual %0b", want.found, got.found);
        fail_cnt++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        fail_cnt++;
      end
      hop_cnt++;
      cur_len++;
      if (want.last) begin
        if (want.found) begin
          path_cnt++;
          if (cur_len > longest_path) longest_path = cur_len;
        end
        cur_len = 0;
      end
    end
  endtask

  // monitor: accept on rising edge
  always @(posedge clk) begin
    in_took  = rst_n && in_valid && in_ready;
    out_took = rst_n && out_valid && out_ready;
    if (in_took) begin
      trace_path(in_data);
      txn_cnt++;
    end
    if (out_took) check_hop(out_data);
  end

  // driver
  always @(negedge clk) begin
    logic    nxt_valid;
    ppr_in_t nxt_data;
    nxt_valid = in_valid;
    nxt_data  = in_data;
    if (rst_n) begin
      if (in_took) nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() != 0 &&
                     !(pending_hold[0] && expected_hops.size() != 0)) begin
          nxt_data  = pending_items.pop_front();
          void'(pending_hold.pop_front());
          nxt_valid = 1'b1;
          if ($urandom_range(0, 11) == 0) send_calm = ~send_calm;
          send_gap = draw_wait(send_calm);
        end
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_took) begin
        if ($urandom_range(0, 11) == 0) recv_calm = ~recv_calm;
        recv_stall = draw_wait(recv_calm);
      end else if (recv_stall == 0 && !recv_calm && $urandom_range(0, 19) == 0) begin
        recv_stall = $urandom_range(1, MAX_WAIT);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > cycle_limit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAIL parent_path_rebuild_top");
      $finish;
    end
  end

  initial begin
    int target, sel;
    cycle_limit = 1000000;

    // directed
    put_write(0, 63);
    put_query(0, 0);
    put_write(63, 0);
    put_query(63, 63);
    put_write(1, 63);
    put_query(63, 1);
    put_query(5, 1);
    put_query(0, 1);
    put_write(2, 3);
    put_write(3, 2);
    put_query(2, 2);
    put_write(21, 63);
    put_write(42, 21);
    put_query(63, 42);
    put_query(63, 63);
    hold_last();
    put_write(1, 0);
    put_query(1, 1);
    put_write(62, 1);
    put_query(1, 62);
    put_query(63, 62);

    // random
    target = live_items + RAND_ITEMS;
    run_chain(NODES - 1, 1'b1);
    hold_last();
    while (live_items < target) begin
      sel = $urandom_range(0, 19);
      if (sel < 13)
        run_chain(($urandom_range(0, 14) == 0) ? $urandom_range(9, 40)
                                               : $urandom_range(1, 8), 1'b0);
      else if (sel < 16)
        put_write(($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, NODES),
                  ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, NODES));
      else
        put_query($urandom_range(0, NODES), $urandom_range(0, NODES));
      if ($urandom_range(0, 24) == 0) hold_last();
    end
    cycle_limit = 4 * pending_items.size() * (NODES * (MAX_WAIT + 1) + 340 + MAX_WAIT) + 1000;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid || expected_hops.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Covered %0d transactions, %0d queries: %0d paths found (longest %0d nodes),",
             txn_cnt, query_cnt, path_cnt, longest_path);
    $display("%0d unreachable or cyclic, %0d results checked.", miss_cnt, hop_cnt);
    if (fail_cnt == 0) begin
      $display("PASS parent_path_rebuild_top");
    end else begin
      $display("FAIL parent_path_rebuild_top");
    end
    $finish;
  end

endmodule
